// File: hdl/glyph_atlas_offset_core_defines.svh
// Assertion macros shared by the glyph atlas offset RTL.
`ifndef GLYPH_ATLAS_OFFSET_CORE_DEFINES_SVH
`define GLYPH_ATLAS_OFFSET_CORE_DEFINES_SVH

// Check a property on a named clock, skipped while the named reset is low.
`define GAO_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on clk_i, skipped while rst_ni is low.
`define GAO_ASSERT(lbl, prop, msg) \
  `GAO_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/gao_pkg.sv
// Types, constants and helper functions for the glyph atlas offset block.
package gao_pkg;

  localparam int BOX_COLS   = 20;
  localparam int BOX_ROWS   = 5;
  localparam int CHAR_FIRST = 32;
  localparam int CHAR_SPAN  = 99;
  localparam int CELL_X_MAX = 59;
  localparam int CELL_Y_MAX = 14;

  // Square-shell placement of boxes 0..7.
  localparam logic [1:0] BOX_COL [8] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] BOX_ROW [8] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1};

  typedef enum logic [2:0] {
    CFG_STYLE_TABLE   = 3'd0,
    CFG_STYLE_COUNT   = 3'd1,
    CFG_DEFAULT_INDEX = 3'd2,
    CFG_GLYPH_WIDTH   = 3'd3,
    CFG_GLYPH_HEIGHT  = 3'd4
  } gao_cfg_e;

  typedef struct packed {
    logic [63:0] style_table;
    logic [3:0]  style_count;
    logic [2:0]  default_style_index;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
  } gao_cfg_t;

  typedef struct packed {
    logic [7:0] style_code;
    logic [7:0] char_code;
  } gao_in_t;

  typedef struct packed {
    logic [13:0] pixel_x;
    logic [11:0] pixel_y;
    logic [5:0]  cell_x;
    logic [3:0]  cell_y;
    logic        style_found;
  } gao_out_t;

  typedef struct packed {
    logic       found;
    logic [2:0] box;
  } gao_match_t;

  typedef struct packed {
    logic [2:0] row;
    logic [4:0] col;
  } gao_cell_t;

  // Split a character index 0..99 into row (div 20) and column (mod 20).
  function automatic gao_cell_t gao_split_index(input logic [6:0] ci);
    gao_cell_t c;
    logic [6:0] base;
    if (ci >= 7'(4 * BOX_COLS)) begin
      c.row = 3'd4;
    end else if (ci >= 7'(3 * BOX_COLS)) begin
      c.row = 3'd3;
    end else if (ci >= 7'(2 * BOX_COLS)) begin
      c.row = 3'd2;
    end else if (ci >= 7'(BOX_COLS)) begin
      c.row = 3'd1;
    end else begin
      c.row = 3'd0;
    end
    base  = 7'({4'd0, c.row} * 7'(BOX_COLS));
    c.col = 5'(ci - base);
    return c;
  endfunction

endpackage

// File: hdl/gao_style_match.sv
// Priority match of a style code against the configured style table.
module gao_style_match #(
  parameter int MAX_STYLES = 8
) (
  input  gao_pkg::gao_cfg_t   cfg_i,
  input  logic [7:0]          style_code_i,
  output gao_pkg::gao_match_t match_o
);
  import gao_pkg::*;

  always_comb begin
    match_o.found = 1'b0;
    match_o.box   = cfg_i.default_style_index;
    // Walk downward so the lowest matching entry wins.
    for (int k = MAX_STYLES - 1; k >= 0; k--) begin
      if ((4'(k) < cfg_i.style_count) && (cfg_i.style_table[8*k +: 8] == style_code_i)) begin
        match_o.found = 1'b1;
        match_o.box   = 3'(k);
      end
    end
  end

endmodule

// File: hdl/gao_cell_map.sv
// Cell and pixel offset of a glyph from its box and character code.
module gao_cell_map (
  input  gao_pkg::gao_cfg_t   cfg_i,
  input  logic [7:0]          char_code_i,
  input  gao_pkg::gao_match_t match_i,
  output gao_pkg::gao_out_t   result_o
);
  import gao_pkg::*;

  logic [6:0] char_idx;
  gao_cell_t  char_pos;
  logic [5:0] cell_x;
  logic [3:0] cell_y;

  always_comb begin
    // Drop out-of-range characters to cell zero of the box.
    if ((char_code_i >= 8'(CHAR_FIRST)) && (char_code_i <= 8'(CHAR_FIRST + CHAR_SPAN))) begin
      char_idx = 7'(char_code_i - 8'(CHAR_FIRST));
    end else begin
      char_idx = 7'd0;
    end
    char_pos = gao_split_index(char_idx);
    cell_x   = 6'({4'd0, BOX_COL[match_i.box]} * 6'(BOX_COLS)) + {1'b0, char_pos.col};
    cell_y   = 4'({2'd0, BOX_ROW[match_i.box]} * 4'(BOX_ROWS)) + {1'b0, char_pos.row};

    result_o.pixel_x     = {8'd0, cell_x} * {6'd0, cfg_i.glyph_width};
    result_o.pixel_y     = {8'd0, cell_y} * {4'd0, cfg_i.glyph_height};
    result_o.cell_x      = cell_x;
    result_o.cell_y      = cell_y;
    result_o.style_found = match_i.found;
  end

endmodule

// File: hdl/glyph_atlas_offset_core.sv
// Top level of the glyph atlas offset block: config registers and two-register pipeline.
//
//   port group   direction  handshake            beat
//   cfg_*        in         cfg_valid/cfg_ready  register index + 64-bit data
//   in_*         in         in_valid/in_stall    style_code, char_code
//   out_*        out        out_valid/out_stall  pixel_x/y, cell_x/y, style_found
//
// One beat accepted per cycle while in_stall_o is low; its result is registered in two steps
// (input register, then result register after lookup, cell split and multiply).
// Reset clears all config registers to zero and empties both stages.
// A stalled output holds its beat; the input register still takes a beat while
// the result register is stalled, as long as the input register is empty.
`include "glyph_atlas_offset_core_defines.svh"
module glyph_atlas_offset_core #(
  parameter int MAX_STYLES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gao_pkg::gao_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gao_pkg::gao_out_t out_data_o
);
  import gao_pkg::*;

  gao_cfg_t   cfg_q;
  logic       s1_valid_q;
  gao_in_t    s1_data_q;
  logic       out_valid_q;
  gao_out_t   out_data_q;
  logic       s1_adv;
  gao_match_t match;
  gao_out_t   result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gao_cfg_e'(cfg_index_i))
        CFG_STYLE_TABLE:   cfg_q.style_table         <= cfg_data_i;
        CFG_STYLE_COUNT:   cfg_q.style_count         <= cfg_data_i[3:0];
        CFG_DEFAULT_INDEX: cfg_q.default_style_index <= cfg_data_i[2:0];
        CFG_GLYPH_WIDTH:   cfg_q.glyph_width         <= cfg_data_i[7:0];
        CFG_GLYPH_HEIGHT:  cfg_q.glyph_height        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
    if (s1_valid_q && s1_adv) begin
      out_data_q <= result;
    end
  end

  gao_style_match #(
    .MAX_STYLES(MAX_STYLES)
  ) u_match (
    .cfg_i       (cfg_q),
    .style_code_i(s1_data_q.style_code),
    .match_o     (match)
  );

  gao_cell_map u_cell (
    .cfg_i      (cfg_q),
    .char_code_i(s1_data_q.char_code),
    .match_i    (match),
    .result_o   (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `GAO_ASSERT(a_stall_needs_beat, in_stall_o |-> s1_valid_q, "input stalled with empty stage")
  `GAO_ASSERT(a_free_slot_advances, (s1_valid_q && !out_valid_q) |=> out_valid_q, "beat not advanced")
  `GAO_ASSERT(a_cell_x_range, out_valid_o |-> (out_data_o.cell_x <= 6'(CELL_X_MAX)), "cell_x out of range")
  `GAO_ASSERT(a_cell_y_range, out_valid_o |-> (out_data_o.cell_y <= 4'(CELL_Y_MAX)), "cell_y out of range")

endmodule
